[sv/rcfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared constants and types of the RC channel frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

   localparam int CHANNEL_COUNT_DEF = 14;

   localparam int BYTE_W   = 8;
   localparam int HI_W     = 4;
   localparam int VAL_W    = BYTE_W + HI_W;
   localparam int CH_IDX_W = 4;
   localparam int POS_W    = 5;
   localparam int SUM_W    = 16;
   localparam int LIMIT_W  = 16;
   localparam int QUIET_W  = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd20;
   localparam logic [QUIET_W-1:0] QUIET_MAX   = 16'hFFFF;
   localparam logic [BYTE_W-1:0]  HDR_FIRST   = 8'h20;
   localparam logic [BYTE_W-1:0]  HDR_SECOND  = 8'h40;

   // input item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // result kinds
   localparam logic RESULT_CHANNEL = 1'b0;
   localparam logic RESULT_TIMEOUT = 1'b1;

   // channel store: two banks of sixteen slots, address is {bank, channel}
   localparam int MEM_AW    = CH_IDX_W + 1;
   localparam int MEM_DEPTH = 1 << MEM_AW;

   // command queue between front and back
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic is_timeout;
      logic bank;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic              hi;
      logic [MEM_AW-1:0] addr;
      logic [BYTE_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic en;
      logic bank;
   } release_type;

endpackage
`default_nettype wire

[sv/rcfd_cmd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_cmd_fifo
// Short command queue between the frame parser and the result sequencer.
// ----------------------------------------------------------------------------
module rcfd_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rcfd_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output rcfd_pkg::cmd_type     head_cmd,
   output logic                  empty,
   output logic                  full
);
   import rcfd_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   cmd_type            entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(FIFO_DEPTH));
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

[sv/rcfd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_front
// Frame parser and link watchdog: takes bytes and ticks, checks frames and
// queues emit and timeout commands.
// ----------------------------------------------------------------------------
module rcfd_front #(
   parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_kind,
   input  wire logic [rcfd_pkg::BYTE_W-1:0]   req_byte_value,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rcfd_pkg::LIMIT_W-1:0]  csr_timeout_limit_ms,
   input  wire logic                          fifo_full,
   output logic                               push,
   output rcfd_pkg::cmd_type                  push_cmd,
   output rcfd_pkg::wr_type                   mem_wr,
   input  wire rcfd_pkg::release_type         bank_release
);
   import rcfd_pkg::*;

   localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_HDR2    = POS_W'(1);
   localparam logic [POS_W-1:0] POS_DATA    = POS_W'(2);
   localparam logic [POS_W-1:0] POS_CK_LOW  = POS_W'(2 + 2 * CHANNEL_COUNT);
   localparam logic [POS_W-1:0] POS_CK_HIGH = POS_W'(3 + 2 * CHANNEL_COUNT);

   logic [LIMIT_W-1:0] limit_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [QUIET_W-1:0] quiet_ff, quiet_in;
   logic               link_ff, link_in;
   logic               bank_ff, bank_in;
   logic [1:0]         busy_ff, busy_in;

   logic               accept;
   logic [POS_W-1:0]   pos_rel;
   logic [SUM_W-1:0]   sum_add;
   logic [SUM_W-1:0]   sum_inv;
   logic [QUIET_W-1:0] quiet_inc;

   assign csr_ready = 1'b1;
   // hold input while the queue is full or the bank to be filled is not yet fully read
   assign req_ready = !fifo_full && !busy_ff[bank_ff];
   assign accept    = req_valid && req_ready;

   assign pos_rel   = pos_ff - POS_DATA;
   assign sum_add   = sum_ff + SUM_W'(req_byte_value);
   assign sum_inv   = ~sum_ff;
   assign quiet_inc = (quiet_ff != QUIET_MAX) ? quiet_ff + 1'b1 : quiet_ff;

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      quiet_in = quiet_ff;
      link_in  = link_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      push     = 1'b0;
      push_cmd = '0;
      mem_wr   = '0;

      if (bank_release.en) begin
         busy_in[bank_release.bank] = 1'b0;
      end

      if (accept) begin
         if (req_kind == KIND_TICK) begin
            quiet_in = quiet_inc;
            if (link_ff && (quiet_inc > limit_ff)) begin
               link_in             = 1'b0;
               push                = 1'b1;
               push_cmd.is_timeout = 1'b1;
            end
         end else if (pos_ff == POS_HUNT) begin
            if (req_byte_value == HDR_FIRST) begin
               sum_in = SUM_W'(HDR_FIRST);
               pos_in = POS_HDR2;
            end else begin
               sum_in = '0;
            end
         end else if (pos_ff == POS_HDR2) begin
            if (req_byte_value == HDR_SECOND) begin
               sum_in = sum_add;
               pos_in = POS_DATA;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff < POS_CK_LOW) begin
            sum_in       = sum_add;
            pos_in       = pos_ff + 1'b1;
            mem_wr.en    = 1'b1;
            mem_wr.hi    = pos_rel[0];
            mem_wr.addr  = {bank_ff, pos_rel[POS_W-1:1]};
            mem_wr.data  = req_byte_value;
         end else if (pos_ff == POS_CK_LOW) begin
            sum_in = sum_inv;
            pos_in = (sum_inv[BYTE_W-1:0] == req_byte_value) ? POS_CK_HIGH : POS_HUNT;
         end else begin
            pos_in = POS_HUNT;
            if ((pos_ff == POS_CK_HIGH) && (sum_ff[SUM_W-1:BYTE_W] == req_byte_value)) begin
               // good frame: hand the filled bank to the back end and swap
               push                = 1'b1;
               push_cmd.is_timeout = 1'b0;
               push_cmd.bank       = bank_ff;
               busy_in[bank_ff]    = 1'b1;
               bank_in             = ~bank_ff;
               quiet_in            = '0;
               link_in             = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         pos_ff   <= POS_HUNT;
         sum_ff   <= '0;
         quiet_ff <= '0;
         link_ff  <= 1'b0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_timeout_limit_ms;
         end
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         quiet_ff <= quiet_in;
         link_ff  <= link_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

endmodule
`default_nettype wire

[sv/rcfd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_back
// Result sequencer: holds the channel store and plays out queued commands,
// one result per cycle through the output register while rsp_ready is high.
// ----------------------------------------------------------------------------
module rcfd_back #(
   parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rcfd_pkg::cmd_type              head_cmd,
   input  wire logic                           fifo_empty,
   output logic                                pop,
   input  wire rcfd_pkg::wr_type               mem_wr,
   output rcfd_pkg::release_type               bank_release,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_result_kind,
   output logic [rcfd_pkg::CH_IDX_W-1:0]       rsp_channel_index,
   output logic [rcfd_pkg::VAL_W-1:0]          rsp_channel_value,
   output logic                                rsp_last
);
   import rcfd_pkg::*;

   localparam logic [CH_IDX_W-1:0] LAST_IDX = CH_IDX_W'(CHANNEL_COUNT - 1);

   logic [BYTE_W-1:0]   lo_mem [MEM_DEPTH];
   logic [HI_W-1:0]     hi_mem [MEM_DEPTH];

   logic                in_frame_ff, in_frame_in;
   logic [CH_IDX_W-1:0] cur_idx_ff, cur_idx_in;
   logic                cur_bank_ff, cur_bank_in;

   logic                rsp_valid_ff;
   logic                kind_ff;
   logic [CH_IDX_W-1:0] idx_ff;
   logic [VAL_W-1:0]    value_ff;
   logic                last_ff;

   logic                advance;
   logic                emit;
   logic                emit_timeout;
   logic [CH_IDX_W-1:0] sel_idx;
   logic                sel_bank;
   logic                sel_last;
   logic [MEM_AW-1:0]   rd_addr;

   assign advance  = !rsp_valid_ff || rsp_ready;
   assign sel_last = (sel_idx == LAST_IDX);
   assign rd_addr  = {sel_bank, sel_idx};

   always_comb begin
      emit         = 1'b0;
      emit_timeout = 1'b0;
      pop          = 1'b0;
      sel_idx      = cur_idx_ff;
      sel_bank     = cur_bank_ff;
      in_frame_in  = in_frame_ff;
      cur_idx_in   = cur_idx_ff;
      cur_bank_in  = cur_bank_ff;
      bank_release = '0;

      if (advance) begin
         if (in_frame_ff) begin
            emit = 1'b1;
         end else if (!fifo_empty) begin
            pop  = 1'b1;
            emit = 1'b1;
            if (head_cmd.is_timeout) begin
               emit_timeout = 1'b1;
            end else begin
               sel_idx  = '0;
               sel_bank = head_cmd.bank;
            end
         end
      end

      if (emit && !emit_timeout) begin
         cur_idx_in  = sel_idx + 1'b1;
         cur_bank_in = sel_bank;
         in_frame_in = !sel_last;
         // free the bank once its last entry has been read
         if (sel_last) begin
            bank_release.en   = 1'b1;
            bank_release.bank = sel_bank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         if (mem_wr.hi) begin
            hi_mem[mem_wr.addr] <= mem_wr.data[HI_W-1:0];
         end else begin
            lo_mem[mem_wr.addr] <= mem_wr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         cur_idx_ff   <= '0;
         cur_bank_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         cur_idx_ff  <= cur_idx_in;
         cur_bank_ff <= cur_bank_in;
         if (advance) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         kind_ff  <= emit_timeout ? RESULT_TIMEOUT : RESULT_CHANNEL;
         idx_ff   <= emit_timeout ? '0 : sel_idx;
         value_ff <= emit_timeout ? '0 : {hi_mem[rd_addr], lo_mem[rd_addr]};
         last_ff  <= emit_timeout || sel_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_channel_index = idx_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_last          = last_ff;

endmodule
`default_nettype wire

[sv/rc_channel_frame_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Output: a good frame's last checksum byte, or a timeout, queues a command that the
//   back end pops and registers, then one value per cycle while rsp_ready is high.
// Throughput: one input transaction per cycle; ready drops only when the command queue
//   is full or both channel-store banks still wait to be played out.
// Reset: synchronous, active high; parser, watchdog, queue and output are cleared at once,
//   limit returns to 20 ms, no clearing pass.
// ----------------------------------------------------------------------------
// rc_channel_frame_decoder_top
// RC receiver frame decoder with link timeout watch.
// ----------------------------------------------------------------------------
module rc_channel_frame_decoder_top #(
   parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_kind,
   input  wire logic [rcfd_pkg::BYTE_W-1:0]   req_byte_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_result_kind,
   output logic [rcfd_pkg::CH_IDX_W-1:0]      rsp_channel_index,
   output logic [rcfd_pkg::VAL_W-1:0]         rsp_channel_value,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rcfd_pkg::LIMIT_W-1:0]  csr_timeout_limit_ms
);
   import rcfd_pkg::*;

   logic        push;
   cmd_type     push_cmd;
   logic        pop;
   cmd_type     head_cmd;
   logic        fifo_empty;
   logic        fifo_full;
   wr_type      mem_wr;
   release_type bank_release;

   rcfd_front #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_byte_value       (req_byte_value),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_timeout_limit_ms (csr_timeout_limit_ms),
      .fifo_full            (fifo_full),
      .push                 (push),
      .push_cmd             (push_cmd),
      .mem_wr               (mem_wr),
      .bank_release         (bank_release)
   );

   rcfd_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (fifo_empty),
      .full     (fifo_full)
   );

   rcfd_back #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_cmd          (head_cmd),
      .fifo_empty        (fifo_empty),
      .pop               (pop),
      .mem_wr            (mem_wr),
      .bank_release      (bank_release),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

[sv/rcfd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_checker
// Port-level checks of the RC channel frame decoder result stream.
// ----------------------------------------------------------------------------
module rcfd_checker #(
   parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_result_kind,
   input wire logic [rcfd_pkg::CH_IDX_W-1:0] rsp_channel_index,
   input wire logic [rcfd_pkg::VAL_W-1:0]    rsp_channel_value,
   input wire logic                          rsp_last
);
   import rcfd_pkg::*;

   localparam logic [CH_IDX_W-1:0] LAST_IDX = CH_IDX_W'(CHANNEL_COUNT - 1);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_channel_index) && $stable(rsp_channel_value) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_timeout_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == RESULT_TIMEOUT) |->
         rsp_last && (rsp_channel_index == '0) && (rsp_channel_value == '0))
      else $error("timeout result malformed");

   a_last_on_final_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == RESULT_CHANNEL) |->
         (rsp_last == (rsp_channel_index == LAST_IDX)) && (rsp_channel_index <= LAST_IDX))
      else $error("channel index and last flag disagree");

   // channels of a frame come out in ascending order
   a_channel_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_result_kind == RESULT_CHANNEL) && !rsp_last
         ##1 rsp_valid |-> (rsp_result_kind == RESULT_CHANNEL)
         && (rsp_channel_index == $past(rsp_channel_index) + 1'b1))
      else $error("channel sequence broken");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind rc_channel_frame_decoder_top rcfd_checker #(
   .CHANNEL_COUNT (CHANNEL_COUNT)
) u_rcfd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_channel_index (rsp_channel_index),
   .rsp_channel_value (rsp_channel_value),
   .rsp_last          (rsp_last)
);
`default_nettype wire
